[sv/assert_macros.svh]
// assertion helpers, clock and reset are taken from the scope of use
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, off during reset
`define AVT_ASSERT_IMP(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("assertion failed");

// next-cycle implication, off during reset
`define AVT_ASSERT_NXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("assertion failed");

// next-cycle implication that also holds across reset
`define AVT_ASSERT_NXT_ALWAYS(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

[sv/avt_pkg.sv]
package avt_pkg;

   localparam int unsigned CoordW  = 32;
   localparam int unsigned TrigW   = 18;
   localparam int unsigned SinW    = TrigW + 1;
   localparam int unsigned ProdAW  = 2 * CoordW;
   localparam int unsigned ProdBW  = CoordW + SinW;
   localparam int unsigned SumW    = ProdAW + 1;
   localparam int unsigned FracW   = 16;
   localparam int unsigned RndW    = SumW - FracW;
   localparam int unsigned LinW    = CoordW + 1;
   localparam int unsigned ModeW   = 3;
   localparam int unsigned CsrIdxW = 3;
   localparam int unsigned Lanes   = 3;

   localparam logic [ModeW-1:0] MODE_SCALE  = 3'd0;
   localparam logic [ModeW-1:0] MODE_MOVE_X = 3'd1;
   localparam logic [ModeW-1:0] MODE_MOVE_Y = 3'd2;
   localparam logic [ModeW-1:0] MODE_MOVE_Z = 3'd3;
   localparam logic [ModeW-1:0] MODE_ROT_X  = 3'd4;
   localparam logic [ModeW-1:0] MODE_ROT_Y  = 3'd5;
   localparam logic [ModeW-1:0] MODE_ROT_Z  = 3'd6;

   localparam logic [CsrIdxW-1:0] CSR_MODE   = 3'd0;
   localparam logic [CsrIdxW-1:0] CSR_SCALE  = 3'd1;
   localparam logic [CsrIdxW-1:0] CSR_OFFSET = 3'd2;
   localparam logic [CsrIdxW-1:0] CSR_COS    = 3'd3;
   localparam logic [CsrIdxW-1:0] CSR_SIN    = 3'd4;

   localparam logic signed [CoordW-1:0] SCALE_RESET = 32'sd65536;
   localparam logic signed [TrigW-1:0]  COS_RESET   = 18'sd65536;

   localparam logic signed [SumW-1:0] ROUND_HALF =
      {{(SumW - FracW){1'b0}}, 1'b1, {(FracW - 1){1'b0}}};

   localparam logic signed [CoordW-1:0] SAT_MAX = {1'b0, {(CoordW - 1){1'b1}}};
   localparam logic signed [CoordW-1:0] SAT_MIN = {1'b1, {(CoordW - 1){1'b0}}};

   typedef struct packed {
      logic use_mul;
      logic add_en;
   } lane_ctl_type;

   typedef struct packed {
      logic ld1;
      logic ld2;
      logic ld3;
      logic ld4;
   } stage_ld_type;

endpackage

[sv/avt_req_if.sv]
interface avt_req_if;
   logic                                valid;
   logic                                ready;
   logic                                kind;
   logic signed [avt_pkg::CoordW-1:0]   x_in;
   logic signed [avt_pkg::CoordW-1:0]   y_in;
   logic signed [avt_pkg::CoordW-1:0]   z_in;

   modport source (output valid, output kind, output x_in, output y_in, output z_in,
                   input ready);
   modport sink   (input valid, input kind, input x_in, input y_in, input z_in,
                   output ready);
endinterface

[sv/avt_rsp_if.sv]
interface avt_rsp_if;
   logic                                valid;
   logic                                ready;
   logic signed [avt_pkg::CoordW-1:0]   x_out;
   logic signed [avt_pkg::CoordW-1:0]   y_out;
   logic signed [avt_pkg::CoordW-1:0]   z_out;
   logic                                saturated;

   modport source (output valid, output x_out, output y_out, output z_out,
                   output saturated, input ready);
   modport sink   (input valid, input x_out, input y_out, input z_out,
                   input saturated, output ready);
endinterface

[sv/affine_vertex_transform_top.sv]
// channel   dir   handshake        word
// req_ch    in    valid / ready    kind, x_in, y_in, z_in
// rsp_ch    out   valid / ready    x_out, y_out, z_out, saturated
// csr_*     in    csr_we           csr_index, csr_wdata
//
// one word per cycle while rsp_ch stays ready; a taken word passes every stage to rsp_ch
// stages: operand select, multiply, sum and round, clamp; the 32x32 multiply sets the pace
// reset is synchronous: pipeline emptied, registers back to their defaults
// a stage holds only while the stage after it is full and stuck, so bubbles close up
// and req_ch.ready drops only when all four stages are full and rsp_ch is stalled
module affine_vertex_transform_top (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 csr_we,
   input  logic [avt_pkg::CsrIdxW-1:0]          csr_index,
   input  logic [avt_pkg::CoordW-1:0]           csr_wdata,
   avt_req_if.sink                              req_ch,
   avt_rsp_if.source                            rsp_ch
);

   logic [avt_pkg::ModeW-1:0]          mode_ff;
   logic signed [avt_pkg::CoordW-1:0]  scale_ff;
   logic signed [avt_pkg::CoordW-1:0]  offset_ff;
   logic signed [avt_pkg::TrigW-1:0]   cos_ff;
   logic signed [avt_pkg::TrigW-1:0]   sin_ff;

   logic [3:0]                         vld_ff;
   logic [3:0]                         vld_in;
   avt_pkg::stage_ld_type              ld;

   logic signed [avt_pkg::CoordW-1:0]  pt     [avt_pkg::Lanes];
   logic signed [avt_pkg::CoordW-1:0]  mult_b [avt_pkg::Lanes];
   logic signed [avt_pkg::CoordW-1:0]  other  [avt_pkg::Lanes];
   logic signed [avt_pkg::SinW-1:0]    sin_eff[avt_pkg::Lanes];
   avt_pkg::lane_ctl_type              ctl    [avt_pkg::Lanes];
   logic signed [avt_pkg::CoordW-1:0]  res    [avt_pkg::Lanes];
   logic [avt_pkg::Lanes-1:0]          sat;

   logic signed [avt_pkg::CoordW-1:0]  cos_ext;
   logic signed [avt_pkg::SinW-1:0]    sin_pos;
   logic signed [avt_pkg::SinW-1:0]    sin_neg;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff   <= avt_pkg::MODE_SCALE;
         scale_ff  <= avt_pkg::SCALE_RESET;
         offset_ff <= '0;
         cos_ff    <= avt_pkg::COS_RESET;
         sin_ff    <= '0;
      end else if (csr_we) begin
         unique case (csr_index)
            avt_pkg::CSR_MODE:   mode_ff   <= csr_wdata[avt_pkg::ModeW-1:0];
            avt_pkg::CSR_SCALE:  scale_ff  <= csr_wdata;
            avt_pkg::CSR_OFFSET: offset_ff <= csr_wdata;
            avt_pkg::CSR_COS:    cos_ff    <= csr_wdata[avt_pkg::TrigW-1:0];
            avt_pkg::CSR_SIN:    sin_ff    <= csr_wdata[avt_pkg::TrigW-1:0];
            default: begin
            end
         endcase
      end
   end

   // stage advance, from the output backwards
   always_comb begin
      ld.ld4 = !vld_ff[3] || rsp_ch.ready;
      ld.ld3 = !vld_ff[2] || ld.ld4;
      ld.ld2 = !vld_ff[1] || ld.ld3;
      ld.ld1 = !vld_ff[0] || ld.ld2;
      vld_in[0] = ld.ld1 ? req_ch.valid : vld_ff[0];
      vld_in[1] = ld.ld2 ? vld_ff[0]    : vld_ff[1];
      vld_in[2] = ld.ld3 ? vld_ff[1]    : vld_ff[2];
      vld_in[3] = ld.ld4 ? vld_ff[2]    : vld_ff[3];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= vld_in;
      end
   end

   assign req_ch.ready = ld.ld1;

   // per-lane operand select
   always_comb begin
      pt[0]   = req_ch.x_in;
      pt[1]   = req_ch.y_in;
      pt[2]   = req_ch.z_in;
      cos_ext = avt_pkg::CoordW'(cos_ff);
      sin_pos = avt_pkg::SinW'(sin_ff);
      sin_neg = -sin_pos;
      for (int i = 0; i < avt_pkg::Lanes; i++) begin
         mult_b[i]  = scale_ff;
         other[i]   = '0;
         sin_eff[i] = '0;
         ctl[i]     = '0;
      end
      unique case (mode_ff)
         avt_pkg::MODE_SCALE: begin
            // zero factor leaves the point alone
            if (!req_ch.kind && (scale_ff != '0)) begin
               for (int i = 0; i < avt_pkg::Lanes; i++) begin
                  ctl[i].use_mul = 1'b1;
               end
            end
         end
         avt_pkg::MODE_MOVE_X: ctl[0].add_en = !req_ch.kind;
         avt_pkg::MODE_MOVE_Y: ctl[1].add_en = !req_ch.kind;
         avt_pkg::MODE_MOVE_Z: ctl[2].add_en = !req_ch.kind;
         avt_pkg::MODE_ROT_X: begin
            ctl[1].use_mul = 1'b1;
            ctl[2].use_mul = 1'b1;
            mult_b[1]  = cos_ext;
            mult_b[2]  = cos_ext;
            other[1]   = pt[2];
            sin_eff[1] = sin_pos;
            other[2]   = pt[1];
            sin_eff[2] = sin_neg;
         end
         avt_pkg::MODE_ROT_Y: begin
            ctl[0].use_mul = 1'b1;
            ctl[2].use_mul = 1'b1;
            mult_b[0]  = cos_ext;
            mult_b[2]  = cos_ext;
            other[0]   = pt[2];
            sin_eff[0] = sin_pos;
            other[2]   = pt[0];
            sin_eff[2] = sin_neg;
         end
         avt_pkg::MODE_ROT_Z: begin
            ctl[0].use_mul = 1'b1;
            ctl[1].use_mul = 1'b1;
            mult_b[0]  = cos_ext;
            mult_b[1]  = cos_ext;
            other[0]   = pt[1];
            sin_eff[0] = sin_pos;
            other[1]   = pt[0];
            sin_eff[1] = sin_neg;
         end
         default: begin
         end
      endcase
   end

   for (genvar g = 0; g < avt_pkg::Lanes; g++) begin : g_lane
      avt_lane u_lane (
         .clock   (clock),
         .ld      (ld),
         .coord   (pt[g]),
         .mult_b  (mult_b[g]),
         .other   (other[g]),
         .sin_eff (sin_eff[g]),
         .offset  (offset_ff),
         .ctl     (ctl[g]),
         .res     (res[g]),
         .sat     (sat[g])
      );
   end

   assign rsp_ch.valid     = vld_ff[3];
   assign rsp_ch.x_out     = res[0];
   assign rsp_ch.y_out     = res[1];
   assign rsp_ch.z_out     = res[2];
   assign rsp_ch.saturated = |sat;

endmodule

[sv/avt_lane.sv]
module avt_lane (
   input  logic                                clock,
   input  avt_pkg::stage_ld_type               ld,
   input  logic signed [avt_pkg::CoordW-1:0]   coord,
   input  logic signed [avt_pkg::CoordW-1:0]   mult_b,
   input  logic signed [avt_pkg::CoordW-1:0]   other,
   input  logic signed [avt_pkg::SinW-1:0]     sin_eff,
   input  logic signed [avt_pkg::CoordW-1:0]   offset,
   input  avt_pkg::lane_ctl_type               ctl,
   output logic signed [avt_pkg::CoordW-1:0]   res,
   output logic                                sat
);

   // stage 1: operands
   logic signed [avt_pkg::CoordW-1:0]  p1_ff;
   logic signed [avt_pkg::CoordW-1:0]  mb1_ff;
   logic signed [avt_pkg::CoordW-1:0]  oth1_ff;
   logic signed [avt_pkg::SinW-1:0]    se1_ff;
   logic signed [avt_pkg::CoordW-1:0]  add1_ff;
   logic                               mul1_ff;
   logic signed [avt_pkg::CoordW-1:0]  add1_in;

   // stage 2: products and the linear path
   logic signed [avt_pkg::ProdAW-1:0]  prod_a2_ff;
   logic signed [avt_pkg::ProdBW-1:0]  prod_b2_ff;
   logic signed [avt_pkg::LinW-1:0]    lin2_ff;
   logic                               mul2_ff;
   logic signed [avt_pkg::ProdAW-1:0]  prod_a2_in;
   logic signed [avt_pkg::ProdBW-1:0]  prod_b2_in;
   logic signed [avt_pkg::LinW-1:0]    lin2_in;

   // stage 3: summed and rounded value
   logic signed [avt_pkg::RndW-1:0]    val3_ff;
   logic signed [avt_pkg::SumW-1:0]    sum3;
   logic signed [avt_pkg::RndW-1:0]    val3_in;

   // stage 4: clamped result
   logic signed [avt_pkg::CoordW-1:0]  res4_ff;
   logic                               sat4_ff;
   logic signed [avt_pkg::CoordW-1:0]  res4_in;
   logic                               sat4_in;
   logic                               fits;

   assign add1_in = ctl.add_en ? offset : '0;

   always_ff @(posedge clock) begin
      if (ld.ld1) begin
         p1_ff   <= coord;
         mb1_ff  <= mult_b;
         oth1_ff <= other;
         se1_ff  <= sin_eff;
         add1_ff <= add1_in;
         mul1_ff <= ctl.use_mul;
      end
   end

   always_comb begin
      prod_a2_in = p1_ff * mb1_ff;
      prod_b2_in = oth1_ff * se1_ff;
      lin2_in    = avt_pkg::LinW'(p1_ff) + avt_pkg::LinW'(add1_ff);
   end

   always_ff @(posedge clock) begin
      if (ld.ld2) begin
         prod_a2_ff <= prod_a2_in;
         prod_b2_ff <= prod_b2_in;
         lin2_ff    <= lin2_in;
         mul2_ff    <= mul1_ff;
      end
   end

   // add one half, then drop the fraction: round half up
   always_comb begin
      sum3 = avt_pkg::SumW'(prod_a2_ff) + avt_pkg::SumW'(prod_b2_ff) + avt_pkg::ROUND_HALF;
      if (mul2_ff) begin
         val3_in = sum3[avt_pkg::SumW-1:avt_pkg::FracW];
      end else begin
         val3_in = avt_pkg::RndW'(lin2_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (ld.ld3) begin
         val3_ff <= val3_in;
      end
   end

   always_comb begin
      fits = (&val3_ff[avt_pkg::RndW-1:avt_pkg::CoordW-1]) ||
             !(|val3_ff[avt_pkg::RndW-1:avt_pkg::CoordW-1]);
      if (fits) begin
         res4_in = val3_ff[avt_pkg::CoordW-1:0];
      end else if (val3_ff[avt_pkg::RndW-1]) begin
         res4_in = avt_pkg::SAT_MIN;
      end else begin
         res4_in = avt_pkg::SAT_MAX;
      end
      sat4_in = !fits;
   end

   always_ff @(posedge clock) begin
      if (ld.ld4) begin
         res4_ff <= res4_in;
         sat4_ff <= sat4_in;
      end
   end

   assign res = res4_ff;
   assign sat = sat4_ff;

endmodule

[sv/avt_checker.sv]
`include "assert_macros.svh"

module avt_checker (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   input  logic                                 req_ready,
   input  logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   input  logic signed [avt_pkg::CoordW-1:0]    x_out,
   input  logic signed [avt_pkg::CoordW-1:0]    y_out,
   input  logic signed [avt_pkg::CoordW-1:0]    z_out,
   input  logic                                 saturated
);

   // empty after reset
   `AVT_ASSERT_NXT_ALWAYS(a_reset_empty, reset, !rsp_valid)

   // a stalled word holds
   `AVT_ASSERT_NXT(a_rsp_hold, rsp_valid && !rsp_ready,
      rsp_valid && $stable(x_out) && $stable(y_out) && $stable(z_out) && $stable(saturated))

   // input backpressure only when the output side is stuck
   `AVT_ASSERT_IMP(a_ready_low, !req_ready, rsp_valid && !rsp_ready)

   // fixed latency when the output keeps draining
   `AVT_ASSERT_NXT(a_latency,
      req_valid && req_ready ##1 rsp_ready ##1 rsp_ready ##1 rsp_ready, rsp_valid)

endmodule

bind affine_vertex_transform_top avt_checker u_avt_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_ch.valid),
   .req_ready (req_ch.ready),
   .rsp_valid (rsp_ch.valid),
   .rsp_ready (rsp_ch.ready),
   .x_out     (rsp_ch.x_out),
   .y_out     (rsp_ch.y_out),
   .z_out     (rsp_ch.z_out),
   .saturated (rsp_ch.saturated)
);

[tb/affine_vertex_transform_checker.sv]
module affine_vertex_transform_checker
   import avt_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               csr_we,
   input  logic [CsrIdxW-1:0] csr_index,
   input  logic [CoordW-1:0]  csr_wdata,
   avt_req_if                 req_ch,
   avt_rsp_if                 rsp_ch,
   output int                 fail_count,
   output int                 pending,
   output int                 words_checked,
   output int                 clamped_words
);
   timeunit 1ns;
   timeprecision 1ps;

   localparam longint COORD_MAX = 64'sd2147483647;
   localparam longint COORD_MIN = -64'sd2147483648;

   typedef struct packed {
      logic signed [CoordW-1:0] x;
      logic signed [CoordW-1:0] y;
      logic signed [CoordW-1:0] z;
      logic                     sat;
   } point_result_type;

   logic [ModeW-1:0]         mode_r;
   logic signed [CoordW-1:0] scale_r;
   logic signed [CoordW-1:0] offset_r;
   logic signed [TrigW-1:0]  cos_r;
   logic signed [TrigW-1:0]  sin_r;

   point_result_type expected_points[$];

   // add one half, then floor
   function automatic longint round_fix(input longint v);
      return (v + 64'sd32768) >>> FracW;
   endfunction

   function automatic point_result_type transform_point(input logic kind,
                                                        input logic signed [CoordW-1:0] px,
                                                        input logic signed [CoordW-1:0] py,
                                                        input logic signed [CoordW-1:0] pz);
      longint           p [3];
      longint           r [3];
      longint           c;
      longint           s;
      int               a;
      int               b;
      int               i;
      logic             rot;
      point_result_type res;
      p[0] = px;
      p[1] = py;
      p[2] = pz;
      r = p;
      c = cos_r;
      s = sin_r;
      a = 0;
      b = 1;
      rot = 1'b0;
      case (mode_r)
         MODE_SCALE: begin
            if (!kind && scale_r != 0) begin
               for (i = 0; i < 3; i++) r[i] = round_fix(p[i] * longint'(scale_r));
            end
         end
         MODE_MOVE_X: if (!kind) r[0] = p[0] + longint'(offset_r);
         MODE_MOVE_Y: if (!kind) r[1] = p[1] + longint'(offset_r);
         MODE_MOVE_Z: if (!kind) r[2] = p[2] + longint'(offset_r);
         MODE_ROT_X: begin
            a = 1;
            b = 2;
            rot = 1'b1;
         end
         MODE_ROT_Y: begin
            a = 0;
            b = 2;
            rot = 1'b1;
         end
         MODE_ROT_Z: begin
            a = 0;
            b = 1;
            rot = 1'b1;
         end
         default: ;
      endcase
      if (rot) begin
         r[a] = round_fix(p[a] * c + p[b] * s);
         r[b] = round_fix(p[b] * c - p[a] * s);
      end
      res.sat = 1'b0;
      for (i = 0; i < 3; i++) begin
         if (r[i] > COORD_MAX) begin
            r[i] = COORD_MAX;
            res.sat = 1'b1;
         end
         if (r[i] < COORD_MIN) begin
            r[i] = COORD_MIN;
            res.sat = 1'b1;
         end
      end
      res.x = r[0][CoordW-1:0];
      res.y = r[1][CoordW-1:0];
      res.z = r[2][CoordW-1:0];
      return res;
   endfunction

   always @(posedge clock) begin
      point_result_type want;
      if (reset) begin
         mode_r = MODE_SCALE;
         scale_r = SCALE_RESET;
         offset_r = '0;
         cos_r = COS_RESET;
         sin_r = '0;
         expected_points.delete();
         fail_count = 0;
         words_checked = 0;
         clamped_words = 0;
      end else begin
         if (rsp_ch.valid && rsp_ch.ready) begin
            words_checked++;
            if (expected_points.size() == 0) begin
               if (fail_count < 10)
                  $display("unexpected word x=%h y=%h z=%h sat=%b", rsp_ch.x_out,
                           rsp_ch.y_out, rsp_ch.z_out, rsp_ch.saturated);
               fail_count++;
            end else begin
               want = expected_points.pop_front();
               if (want.sat) clamped_words++;
               if (rsp_ch.x_out !== want.x || rsp_ch.y_out !== want.y ||
                   rsp_ch.z_out !== want.z || rsp_ch.saturated !== want.sat) begin
                  if (fail_count < 10)
                     $display("word %0d: expected x=%h y=%h z=%h sat=%b, got x=%h y=%h z=%h sat=%b",
                              words_checked, want.x, want.y, want.z, want.sat, rsp_ch.x_out,
                              rsp_ch.y_out, rsp_ch.z_out, rsp_ch.saturated);
                  fail_count++;
               end
            end
         end
         if (req_ch.valid && req_ch.ready)
            expected_points.push_back(transform_point(req_ch.kind, req_ch.x_in, req_ch.y_in,
                                                      req_ch.z_in));
         if (csr_we) begin
            case (csr_index)
               CSR_MODE:   mode_r = csr_wdata[ModeW-1:0];
               CSR_SCALE:  scale_r = csr_wdata;
               CSR_OFFSET: offset_r = csr_wdata;
               CSR_COS:    cos_r = csr_wdata[TrigW-1:0];
               CSR_SIN:    sin_r = csr_wdata[TrigW-1:0];
               default: ;
            endcase
         end
      end
      pending = expected_points.size();
   end

endmodule

[tb/affine_vertex_transform_top_tb.sv]
module affine_vertex_transform_top_tb;
   timeunit 1ns;
   timeprecision 1ps;
   import avt_pkg::*;

   localparam int               LIMIT        = 200000;
   localparam int               RAND_PHASES  = 16;
   localparam int               PHASE_WORDS  = 70;
   localparam int               HOLD_CYCLES  = 300;
   localparam logic [ModeW-1:0] MODE_UNUSED  = 3'd7;
   localparam logic             KIND_VERTEX  = 1'b0;
   localparam logic             KIND_NORMAL  = 1'b1;

   logic               clock;
   logic               reset;
   logic               csr_we;
   logic [CsrIdxW-1:0] csr_index;
   logic [CoordW-1:0]  csr_wdata;

   avt_req_if req_ch();
   avt_rsp_if rsp_ch();

   int sender_idle    = 0;
   int receiver_stall = 0;
   int hold_requests  = 0;
   int holds_served   = 0;
   int settings       = 1;
   int cycle_count    = 0;
   int fail_count;
   int pending;
   int words_checked;
   int clamped_words;

   logic                     dir_kind [5] = '{KIND_VERTEX, KIND_NORMAL, KIND_VERTEX,
                                              KIND_NORMAL, KIND_VERTEX};
   logic signed [CoordW-1:0] dir_x [5] = '{SAT_MAX, SAT_MIN, -32'sd1, 32'sd1, 32'sd1};
   logic signed [CoordW-1:0] dir_y [5] = '{SAT_MIN, SAT_MAX, 32'sd65536, -32'sd65536,
                                           -32'sd1};
   logic signed [CoordW-1:0] dir_z [5] = '{32'sd0, -32'sd1, SAT_MIN, SAT_MAX, 32'sd3};

   affine_vertex_transform_top dut (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .req_ch    (req_ch),
      .rsp_ch    (rsp_ch)
   );

   affine_vertex_transform_checker chk (
      .clock         (clock),
      .reset         (reset),
      .csr_we        (csr_we),
      .csr_index     (csr_index),
      .csr_wdata     (csr_wdata),
      .req_ch        (req_ch),
      .rsp_ch        (rsp_ch),
      .fail_count    (fail_count),
      .pending       (pending),
      .words_checked (words_checked),
      .clamped_words (clamped_words)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   function automatic logic signed [CoordW-1:0] pick_coord();
      case ($urandom_range(9))
         0: return SAT_MAX;
         1: return SAT_MIN;
         2: return '0;
         3, 4, 5: return CoordW'($urandom_range(2097152)) - 32'sd1048576;
         default: return $urandom();
      endcase
   endfunction

   function automatic logic signed [TrigW-1:0] pick_trig();
      case ($urandom_range(7))
         0: return -18'sd131072;
         1: return 18'sd131071;
         2: return 18'sd65536;
         3: return -18'sd65536;
         default: return TrigW'($urandom_range(131072)) - 18'sd65536;
      endcase
   endfunction

   // valid stays high between back-to-back words, dropped only for a gap
   task automatic send_word(input logic k, input logic signed [CoordW-1:0] x,
                            input logic signed [CoordW-1:0] y,
                            input logic signed [CoordW-1:0] z);
      while ($urandom_range(99) < sender_idle) begin
         req_ch.valid <= 1'b0;
         @(posedge clock);
      end
      req_ch.valid <= 1'b1;
      req_ch.kind  <= k;
      req_ch.x_in  <= x;
      req_ch.y_in  <= y;
      req_ch.z_in  <= z;
      do @(posedge clock); while (!req_ch.ready);
   endtask

   task automatic send_point(input int k);
      send_word(dir_kind[k], dir_x[k], dir_y[k], dir_z[k]);
   endtask

   task automatic write_reg(input logic [CsrIdxW-1:0] idx, input logic [CoordW-1:0] data);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
   endtask

   task automatic program_regs(input logic [ModeW-1:0] m, input logic signed [CoordW-1:0] sf,
                               input logic signed [CoordW-1:0] off,
                               input logic signed [TrigW-1:0] c,
                               input logic signed [TrigW-1:0] s);
      write_reg(CSR_MODE, CoordW'(m));
      write_reg(CSR_SCALE, sf);
      write_reg(CSR_OFFSET, off);
      write_reg(CSR_COS, {{(CoordW - TrigW){c[TrigW-1]}}, c});
      write_reg(CSR_SIN, {{(CoordW - TrigW){s[TrigW-1]}}, s});
      csr_we <= 1'b0;
      settings++;
   endtask

   // wait for the pipeline to drain before touching the registers
   task automatic settle();
      req_ch.valid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   initial begin
      forever begin
         if (holds_served < hold_requests) begin
            rsp_ch.ready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
            holds_served++;
         end else begin
            rsp_ch.ready <= ($urandom_range(99) >= receiver_stall);
            @(posedge clock);
         end
      end
   end

   initial begin
      int ph;
      int n;
      reset        <= 1'b1;
      csr_we       <= 1'b0;
      csr_index    <= CSR_MODE;
      csr_wdata    <= '0;
      req_ch.valid <= 1'b0;
      req_ch.kind  <= KIND_VERTEX;
      req_ch.x_in  <= '0;
      req_ch.y_in  <= '0;
      req_ch.z_in  <= '0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // directed: every mode, register extremes, zero scale, ties, trig past unity
      send_point(0);
      send_point(1);
      settle();
      program_regs(MODE_SCALE, '0, '0, COS_RESET, '0);
      send_point(2);
      send_point(3);
      settle();
      program_regs(MODE_SCALE, SAT_MIN, SAT_MAX, COS_RESET, '0);
      send_point(0);
      send_point(4);
      settle();
      program_regs(MODE_SCALE, 32'sd32768, '0, COS_RESET, '0);
      send_point(4);
      send_point(1);
      settle();
      program_regs(MODE_MOVE_X, SCALE_RESET, SAT_MAX, COS_RESET, '0);
      send_point(0);
      send_point(1);
      settle();
      program_regs(MODE_MOVE_Y, SCALE_RESET, SAT_MIN, COS_RESET, '0);
      send_point(0);
      send_point(3);
      settle();
      program_regs(MODE_MOVE_Z, SCALE_RESET, 32'sd98304, COS_RESET, '0);
      send_point(2);
      send_point(3);
      settle();
      program_regs(MODE_ROT_X, SCALE_RESET, '0, 18'sd46341, 18'sd46341);
      send_point(0);
      send_point(1);
      settle();
      program_regs(MODE_ROT_Y, SCALE_RESET, '0, -18'sd131072, 18'sd131071);
      send_point(2);
      send_point(3);
      settle();
      program_regs(MODE_ROT_Z, SCALE_RESET, '0, '0, -18'sd65536);
      send_point(0);
      send_point(4);
      settle();
      program_regs(MODE_UNUSED, SAT_MAX, SAT_MAX, 18'sd131071, -18'sd131072);
      send_point(1);
      send_point(2);

      for (ph = 0; ph < RAND_PHASES; ph++) begin
         settle();
         case (ph % 4)
            0: begin
               sender_idle = 0;
               receiver_stall = 0;
            end
            1: begin
               sender_idle = 82;
               receiver_stall = 0;
            end
            2: begin
               sender_idle = 0;
               receiver_stall = 82;
            end
            default: begin
               sender_idle = 33;
               receiver_stall = 33;
            end
         endcase
         program_regs(ModeW'(ph % 8), pick_coord(), pick_coord(), pick_trig(), pick_trig());
         // output held off while words keep coming, so the input backs up
         if (ph == 4) hold_requests <= hold_requests + 1;
         for (n = 0; n < PHASE_WORDS; n++)
            send_word(1'($urandom_range(1)), pick_coord(), pick_coord(), pick_coord());
      end
      settle();

      $display("%0d words checked under %0d register settings, %0d with clamped coordinates",
               words_checked, settings, clamped_words);
      $display("all mode codes, positions and normals, trig past unity, one long output hold");
      if (fail_count == 0 && pending == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

   initial begin
      while (cycle_count < LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("timeout after %0d cycles, %0d words still expected", cycle_count, pending);
      $display("Test completed with failures");
      $finish;
   end

endmodule
